// ===== rtl/flowcnt_pkg.sv =====
`timescale 1ns / 1ps

package flowcnt_pkg;

   // table geometry
   localparam int FLOW_ENTRIES = 64;
   localparam int COUNT_BITS   = 32;
   localparam int LANES        = (FLOW_ENTRIES < 16) ? (2 ** $clog2(FLOW_ENTRIES)) : 16;
   localparam int ROWS         = (FLOW_ENTRIES + LANES - 1) / LANES;
   localparam int ENTRY_BITS   = $clog2(FLOW_ENTRIES);
   localparam int LANE_BITS    = $clog2(LANES);
   localparam int ROW_BITS     = (ROWS > 1) ? $clog2(ROWS) : 1;

   // fixed field widths
   localparam int SLOT_BITS    = 6;
   localparam int PKT_BITS     = 32;
   localparam int CSR_ADDR_BITS = 3;

   // protocol numbers and ethertype
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;

   // protocol class codes
   localparam logic [1:0] CLASS_TCP   = 2'd0;
   localparam logic [1:0] CLASS_UDP   = 2'd1;
   localparam logic [1:0] CLASS_ICMP  = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   // register index
   localparam logic [CSR_ADDR_BITS-3:0] REG_LOCAL_ADDR = '0;

   typedef struct packed {
      logic [15:0] frame_type;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [7:0]  proto_number;
   } req_type;

   typedef struct packed {
      logic                 counted;
      logic [1:0]           proto_class;
      logic [SLOT_BITS-1:0] flow_slot;
      logic [PKT_BITS-1:0]  flow_packets;
      logic                 new_flow;
      logic                 table_full;
      logic [31:0]          frames_seen;
   } rsp_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [1:0]  proto_class;
   } key_type;

   // command into the key table
   typedef struct packed {
      logic                  start;
      logic                  insert;
      logic [ENTRY_BITS-1:0] insert_slot;
      key_type               key;
   } tbl_cmd_type;

   // lookup outcome from the key table
   typedef struct packed {
      logic                  done;
      logic                  hit;
      logic [ENTRY_BITS-1:0] hit_slot;
      logic                  free;
      logic [ENTRY_BITS-1:0] free_slot;
   } tbl_res_type;

   function automatic logic [1:0] class_of(input logic [7:0] proto);
      logic [1:0] cls;
      case (proto)
         PROTO_TCP:  cls = CLASS_TCP;
         PROTO_UDP:  cls = CLASS_UDP;
         PROTO_ICMP: cls = CLASS_ICMP;
         default:    cls = CLASS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

// ===== rtl/flowcnt_key_table.sv =====
`timescale 1ns / 1ps

module flowcnt_key_table (
   input  logic                     clock,
   input  logic                     reset,
   input  flowcnt_pkg::tbl_cmd_type cmd,
   output flowcnt_pkg::tbl_res_type res
);
   import flowcnt_pkg::*;

   // key memory, one row of lanes per read
   key_type key_mem [ROWS][LANES];
   key_type key_rd_ff [LANES];

   logic [FLOW_ENTRIES-1:0] valid_ff;

   logic                  active_ff, active_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  look_ok_ff, look_ok_in;
   logic [ROW_BITS-1:0]   look_row_ff, look_row_in;
   logic                  hit_ff, hit_in;
   logic [ENTRY_BITS-1:0] hit_slot_ff, hit_slot_in;
   logic                  free_ff, free_in;
   logic [ENTRY_BITS-1:0] free_slot_ff, free_slot_in;
   logic                  done_ff, done_in;

   logic                  issue;
   logic [ENTRY_BITS-1:0] lane_entry [LANES];
   logic [LANES-1:0]      lane_valid;
   logic [LANES-1:0]      lane_exists;
   logic                  row_hit, row_free;
   logic [ENTRY_BITS-1:0] row_hit_slot, row_free_slot;
   logic [ROW_BITS-1:0]   wr_row;
   logic [LANE_BITS-1:0]  wr_lane;

   assign issue   = active_ff && !issue_done_ff && !cmd.start;
   assign wr_row  = ROW_BITS'(cmd.insert_slot >> LANE_BITS);
   assign wr_lane = LANE_BITS'(cmd.insert_slot);

   // entry numbers and valid marks of the row under compare
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_entry[l]  = ENTRY_BITS'(int'(look_row_ff) * LANES + l);
         lane_exists[l] = (int'(look_row_ff) * LANES + l) < FLOW_ENTRIES;
         lane_valid[l]  = lane_exists[l] && valid_ff[lane_entry[l]];
      end
   end

   // lowest matching lane and lowest free lane of the row
   always_comb begin
      row_hit       = 1'b0;
      row_hit_slot  = '0;
      row_free      = 1'b0;
      row_free_slot = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_valid[l] && key_rd_ff[l] == cmd.key) begin
            row_hit      = 1'b1;
            row_hit_slot = lane_entry[l];
         end
         if (lane_exists[l] && !lane_valid[l]) begin
            row_free      = 1'b1;
            row_free_slot = lane_entry[l];
         end
      end
   end

   // scan sequencer: issue one row read a cycle, compare it the next
   always_comb begin
      active_in     = active_ff;
      row_in        = row_ff;
      issue_done_in = issue_done_ff;
      look_ok_in    = 1'b0;
      look_row_in   = look_row_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      done_in       = 1'b0;
      if (cmd.start) begin
         active_in     = 1'b1;
         row_in        = '0;
         issue_done_in = 1'b0;
         hit_in        = 1'b0;
         free_in       = 1'b0;
      end else if (active_ff) begin
         if (!issue_done_ff) begin
            look_ok_in  = 1'b1;
            look_row_in = row_ff;
            row_in      = row_ff + 1'b1;
            if (row_ff == ROW_BITS'(ROWS - 1)) begin
               issue_done_in = 1'b1;
            end
         end
         if (look_ok_ff) begin
            if (!hit_ff && row_hit) begin
               hit_in      = 1'b1;
               hit_slot_in = row_hit_slot;
            end
            if (!free_ff && row_free) begin
               free_in      = 1'b1;
               free_slot_in = row_free_slot;
            end
            if (issue_done_ff) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         active_ff     <= 1'b0;
         issue_done_ff <= 1'b0;
         look_ok_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (cmd.insert) begin
            valid_ff[cmd.insert_slot] <= 1'b1;
         end
         active_ff     <= active_in;
         issue_done_ff <= issue_done_in;
         look_ok_ff    <= look_ok_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      look_row_ff  <= look_row_in;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
   end

   // key memory ports
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_mem[wr_row][wr_lane] <= cmd.key;
      end
      if (issue) begin
         for (int l = 0; l < LANES; l++) begin
            key_rd_ff[l] <= key_mem[row_ff][l];
         end
      end
   end

   assign res.done      = done_ff;
   assign res.hit       = hit_ff;
   assign res.hit_slot  = hit_slot_ff;
   assign res.free      = free_ff;
   assign res.free_slot = free_slot_ff;

endmodule

// ===== rtl/ipv4_flow_counter.sv =====
`timescale 1ns / 1ps

// IPv4 flow counter
// Input channel req_*: one word of parsed header fields per frame. Output
// channel rsp_*: exactly one result word per input word, in order. Both use
// valid/ready. The APB-style port sets local_address at byte address 0.
// A frame that is IPv4 and touches local_address is looked up by its
// (source, destination, class) key; a hit bumps the saturating count, a miss
// takes the lowest free entry, and with no entry free table_full is reported.
// Timing: the key table is swept one memory row of 16 entries a cycle; a hit
// adds a count read-modify-write state (ST_COUNT) before the result, a new
// or full-table frame goes straight to ST_DONE, and a frame that is not
// counted skips the sweep. The result word is loaded into the output register
// as the block returns to idle, before input is taken again. One frame is in
// the lookup at a time.
// Reset clears all entry valid marks at once, the frame total and the local
// address; no clearing pass is needed. If the receiver stalls, the finished
// word waits in the output register while the next frame is still accepted
// and processed; that frame then holds until the output register drains.

module ipv4_flow_counter (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  flowcnt_pkg::req_type req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output flowcnt_pkg::rsp_type rsp_data,

   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [flowcnt_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import flowcnt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [31:0]           local_addr_ff;
   logic [31:0]           frame_total_ff, frame_total_in;
   key_type               key_ff, key_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   tbl_cmd_type           tbl_cmd;
   tbl_res_type           tbl_res;

   // packet count memory
   logic [COUNT_BITS-1:0] count_mem [FLOW_ENTRIES];
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [COUNT_BITS-1:0] count_next;
   logic                  cnt_we, cnt_re;
   logic [ENTRY_BITS-1:0] cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;

   logic                  frame_local;
   logic                  csr_write;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[CSR_ADDR_BITS-1:2] == REG_LOCAL_ADDR);
   assign prdata    = (paddr[CSR_ADDR_BITS-1:2] == REG_LOCAL_ADDR) ? local_addr_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_write) begin
         local_addr_ff <= pwdata;
      end
   end

   assign frame_local = (req_data.frame_type == ETHERTYPE_IPV4)
                        && (req_data.source_address == local_addr_ff
                            || req_data.dest_address == local_addr_ff);

   // saturating increment of the read count
   assign count_next = (&count_rd_ff) ? count_rd_ff : count_rd_ff + 1'b1;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame sequencer
   always_comb begin
      state_in       = state_ff;
      frame_total_in = frame_total_ff;
      key_in         = key_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      tbl_cmd        = '0;
      tbl_cmd.key    = key_ff;
      tbl_cmd.insert_slot = tbl_res.free_slot;
      cnt_we         = 1'b0;
      cnt_re         = 1'b0;
      cnt_waddr      = tbl_res.free_slot;
      cnt_wdata      = COUNT_BITS'(1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frame_total_in            = frame_total_ff + 1'b1;
               res_in                    = '0;
               res_in.frames_seen        = frame_total_ff + 1'b1;
               key_in.source_address     = req_data.source_address;
               key_in.dest_address       = req_data.dest_address;
               key_in.proto_class        = class_of(req_data.proto_number);
               if (frame_local) begin
                  res_in.proto_class = class_of(req_data.proto_number);
                  tbl_cmd.start      = 1'b1;
                  state_in           = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (tbl_res.done) begin
               if (tbl_res.hit) begin
                  cnt_re   = 1'b1;
                  state_in = ST_COUNT;
               end else if (tbl_res.free) begin
                  tbl_cmd.insert      = 1'b1;
                  cnt_we              = 1'b1;
                  res_in.counted      = 1'b1;
                  res_in.flow_slot    = SLOT_BITS'(tbl_res.free_slot);
                  res_in.flow_packets = PKT_BITS'(1);
                  res_in.new_flow     = 1'b1;
                  state_in            = ST_DONE;
               end else begin
                  res_in.table_full = 1'b1;
                  state_in          = ST_DONE;
               end
            end
         end
         ST_COUNT: begin
            cnt_we              = 1'b1;
            cnt_waddr           = tbl_res.hit_slot;
            cnt_wdata           = count_next;
            res_in.counted      = 1'b1;
            res_in.flow_slot    = SLOT_BITS'(tbl_res.hit_slot);
            res_in.flow_packets = PKT_BITS'(count_next);
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_total_ff <= frame_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // count memory ports
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         count_rd_ff <= count_mem[tbl_res.hit_slot];
      end
   end

   flowcnt_key_table u_key_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .res   (tbl_res)
   );

endmodule

// ===== rtl/flowcnt_checker.sv =====
`timescale 1ns / 1ps

module flowcnt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input flowcnt_pkg::rsp_type rsp_data
);
   import flowcnt_pkg::*;

   // one frame in the lookup at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after acceptance");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a new flow starts at one and is counted
   a_new_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_flow |->
         rsp_data.counted && rsp_data.flow_packets == PKT_BITS'(1))
      else $error("new flow without count of one");

   // a full table stores nothing
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         !rsp_data.counted && !rsp_data.new_flow && rsp_data.flow_slot == '0
         && rsp_data.flow_packets == '0)
      else $error("table full result carries flow data");

   // after reset nothing is pending and input is open
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind ipv4_flow_counter flowcnt_checker u_flowcnt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/ipv4_flow_counter_test.sv =====
`timescale 1ns / 1ps

module ipv4_flow_counter_test;
   import flowcnt_pkg::*;

   localparam int POOL_SIZE = 12;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_ADDR_BITS-1:0] LOCAL_ADDR_OFFSET = CSR_ADDR_BITS'(REG_LOCAL_ADDR) << 2;

   // one row of the directed sequence
   typedef struct {
      req_type frame;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow of the flow table and counters
   logic                  flow_live [FLOW_ENTRIES];
   logic [31:0]           flow_src [FLOW_ENTRIES];
   logic [31:0]           flow_dst [FLOW_ENTRIES];
   logic [1:0]            flow_cls [FLOW_ENTRIES];
   logic [COUNT_BITS-1:0] flow_count [FLOW_ENTRIES];
   logic [31:0]           frame_count = '0;
   logic [31:0]           local_ip = '0;

   rsp_type      expected_results [$];
   stim_row_type directed_rows [$];
   logic [31:0]  remote_pool [POOL_SIZE];
   int           pool_used = POOL_SIZE;
   int           mismatch_count = 0;
   bit           calm = 1'b0;

   ipv4_flow_counter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // protocol number to class code
   function automatic logic [1:0] proto_to_class(input logic [7:0] proto);
      if (proto == PROTO_TCP) return CLASS_TCP;
      if (proto == PROTO_UDP) return CLASS_UDP;
      if (proto == PROTO_ICMP) return CLASS_ICMP;
      return CLASS_OTHER;
   endfunction

   // update the shadow table with one frame and return its result word
   function automatic rsp_type count_frame(input req_type w);
      rsp_type r;
      int      hit;
      int      vacant;
      logic [1:0] cls;
      r = '0;
      hit = -1;
      vacant = -1;
      frame_count = frame_count + 32'd1;
      r.frames_seen = frame_count;
      if (w.frame_type == ETHERTYPE_IPV4 &&
          (w.source_address == local_ip || w.dest_address == local_ip)) begin
         cls = proto_to_class(w.proto_number);
         r.proto_class = cls;
         for (int i = 0; i < FLOW_ENTRIES; i++) begin
            if (flow_live[i]) begin
               if (hit < 0 && flow_src[i] == w.source_address &&
                   flow_dst[i] == w.dest_address && flow_cls[i] == cls)
                  hit = i;
            end else if (vacant < 0) begin
               vacant = i;
            end
         end
         if (hit >= 0) begin
            // saturating count
            if (flow_count[hit] != '1)
               flow_count[hit] = flow_count[hit] + 1'b1;
            r.counted = 1'b1;
            r.flow_slot = SLOT_BITS'(hit);
            r.flow_packets = PKT_BITS'(flow_count[hit]);
         end else if (vacant >= 0) begin
            flow_live[vacant] = 1'b1;
            flow_src[vacant] = w.source_address;
            flow_dst[vacant] = w.dest_address;
            flow_cls[vacant] = cls;
            flow_count[vacant] = COUNT_BITS'(1);
            r.counted = 1'b1;
            r.flow_slot = SLOT_BITS'(vacant);
            r.flow_packets = PKT_BITS'(1);
            r.new_flow = 1'b1;
         end else begin
            r.table_full = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic rsp_type make_result(input logic c, input logic [1:0] cls,
                                           input int slot, input logic [31:0] pkts,
                                           input logic fresh, input logic full,
                                           input logic [31:0] frames);
      rsp_type r;
      r.counted = c;
      r.proto_class = cls;
      r.flow_slot = SLOT_BITS'(slot);
      r.flow_packets = pkts;
      r.new_flow = fresh;
      r.table_full = full;
      r.frames_seen = frames;
      return r;
   endfunction

   function automatic void add_row(input logic [15:0] et, input logic [31:0] src,
                                   input logic [31:0] dst, input logic [7:0] proto,
                                   input bit typed, input rsp_type r);
      stim_row_type row;
      row.frame.frame_type = et;
      row.frame.source_address = src;
      row.frame.dest_address = dst;
      row.frame.proto_number = proto;
      row.typed = typed;
      row.result = r;
      directed_rows.push_back(row);
   endfunction

   // mostly well-formed frames on the watched address, some noise
   function automatic req_type make_frame();
      req_type w;
      logic [31:0] remote_ip;
      int pick;
      pick = $urandom_range(0, 99);
      remote_ip = remote_pool[$urandom_range(0, pool_used - 1)];
      w.frame_type = ETHERTYPE_IPV4;
      case ($urandom_range(0, 3))
         0: w.proto_number = PROTO_TCP;
         1: w.proto_number = PROTO_UDP;
         2: w.proto_number = PROTO_ICMP;
         default: w.proto_number = 8'($urandom_range(0, 255));
      endcase
      w.source_address = local_ip;
      w.dest_address = remote_ip;
      if (pick >= 40 && pick < 70) begin
         w.source_address = remote_ip;
         w.dest_address = local_ip;
      end else if (pick >= 70 && pick < 78) begin
         w.dest_address = local_ip;
      end else if (pick >= 78 && pick < 88) begin
         // right addresses, wrong or odd ethertype
         w.frame_type = 16'($urandom_range(0, 65535));
      end else if (pick >= 88) begin
         w.source_address = $urandom;
         w.dest_address = $urandom;
      end
      return w;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = count_frame(w);
      expected_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LOCAL_ADDR_OFFSET;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      local_ip = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read_check();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LOCAL_ADDR_OFFSET;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== local_ip) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("local_address readback: expected %h got %h", local_ip, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // one random phase at a given watched address
   task automatic run_phase(input logic [31:0] addr, input int items, input int span,
                            input int calm_words);
      drain_results();
      csr_write(addr);
      csr_read_check();
      pool_used = span;
      for (int n = 0; n < items; n++) begin
         calm = (n < calm_words);
         // hold the sender once until the block has caught up
         if (n == items / 2)
            drain_results();
         send_word(make_frame(), 1'b0, '0);
      end
      calm = 1'b0;
   endtask

   // receiver backpressure
   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= 18);

   // result checker
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word: frames_seen %0d", rsp_data.frames_seen);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.counted !== want.counted ||
                rsp_data.proto_class !== want.proto_class ||
                rsp_data.flow_slot !== want.flow_slot ||
                rsp_data.flow_packets !== want.flow_packets ||
                rsp_data.new_flow !== want.new_flow ||
                rsp_data.table_full !== want.table_full ||
                rsp_data.frames_seen !== want.frames_seen) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: expected cnt %b cls %0d slot %0d pkts %0d new %b ",
                            "full %b frames %0d, got cnt %b cls %0d slot %0d pkts %0d ",
                            "new %b full %b frames %0d"},
                           want.counted, want.proto_class, want.flow_slot,
                           want.flow_packets, want.new_flow, want.table_full,
                           want.frames_seen, rsp_data.counted, rsp_data.proto_class,
                           rsp_data.flow_slot, rsp_data.flow_packets, rsp_data.new_flow,
                           rsp_data.table_full, rsp_data.frames_seen);
            end
         end
      end
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("ipv4_flow_counter_test failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] first_addr;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
         flow_live[i] = 1'b0;
         flow_src[i] = '0;
         flow_dst[i] = '0;
         flow_cls[i] = '0;
         flow_count[i] = '0;
      end
      remote_pool[0] = 32'h0000_0000;
      remote_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         remote_pool[i] = $urandom;

      // directed rows, watched address still at its reset value of zero
      add_row(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
              make_result(1'b0, CLASS_TCP, 0, 32'd0, 1'b0, 1'b0, 32'd1));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, PROTO_TCP, 1'b1,
              make_result(1'b1, CLASS_TCP, 0, 32'd1, 1'b1, 1'b0, 32'd2));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, PROTO_TCP, 1'b1,
              make_result(1'b1, CLASS_TCP, 0, 32'd2, 1'b0, 1'b0, 32'd3));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, PROTO_UDP, 1'b1,
              make_result(1'b1, CLASS_UDP, 1, 32'd1, 1'b1, 1'b0, 32'd4));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, PROTO_ICMP, 1'b1,
              make_result(1'b1, CLASS_ICMP, 2, 32'd1, 1'b1, 1'b0, 32'd5));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, 8'hFF, 1'b1,
              make_result(1'b1, CLASS_OTHER, 3, 32'd1, 1'b1, 1'b0, 32'd6));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b1,
              make_result(1'b1, CLASS_OTHER, 3, 32'd2, 1'b0, 1'b0, 32'd7));
      // local address on neither side
      add_row(ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h1234_5678, PROTO_TCP, 1'b1,
              make_result(1'b0, CLASS_TCP, 0, 32'd0, 1'b0, 1'b0, 32'd8));
      // reversed direction is a separate flow
      add_row(ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h0, PROTO_TCP, 1'b1,
              make_result(1'b1, CLASS_TCP, 4, 32'd1, 1'b1, 1'b0, 32'd9));
      add_row(16'h0000, 32'h0, 32'h0, PROTO_TCP, 1'b1,
              make_result(1'b0, CLASS_TCP, 0, 32'd0, 1'b0, 1'b0, 32'd10));
      add_row(16'h0801, 32'h0, 32'h0, PROTO_UDP, 1'b1,
              make_result(1'b0, CLASS_TCP, 0, 32'd0, 1'b0, 1'b0, 32'd11));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'h0, PROTO_UDP, 1'b1,
              make_result(1'b1, CLASS_UDP, 5, 32'd1, 1'b1, 1'b0, 32'd12));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'h0, PROTO_UDP, 1'b1,
              make_result(1'b1, CLASS_UDP, 5, 32'd2, 1'b0, 1'b0, 32'd13));
      add_row(ETHERTYPE_IPV4, 32'h0, 32'h8000_0001, 8'h80, 1'b0, '0);
      add_row(ETHERTYPE_IPV4, 32'hA5A5_A5A5, 32'h0, 8'h02, 1'b0, '0);
      add_row(ETHERTYPE_IPV4, 32'h0, 32'hFFFF_FFFF, PROTO_TCP, 1'b0, '0);
      add_row(16'h8100, 32'h0, 32'h0, PROTO_ICMP, 1'b0, '0);
      add_row(ETHERTYPE_IPV4, 32'h5A5A_5A5A, 32'h0, PROTO_UDP, 1'b0, '0);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read_check();

      foreach (directed_rows[i])
         send_word(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].result);

      // small pool first so flows repeat, then wide pools that fill the table
      first_addr = $urandom;
      run_phase(first_addr, 150, 4, 0);
      run_phase(32'hFFFF_FFFF, 150, POOL_SIZE, 100);
      run_phase($urandom, 150, POOL_SIZE, 0);
      // back to the first address: mostly hits on a full table
      run_phase(first_addr, 100, 4, 0);
      run_phase(32'h0000_0000, 50, POOL_SIZE, 0);

      drain_results();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("ipv4_flow_counter_test passed");
      else
         $display("ipv4_flow_counter_test failed");
      $finish;
   end

endmodule
